// File: hdl/threshold_beat_rate_meter_assert.svh
// Assertion macros shared by the checker of the beat rate meter.
`ifndef THRESHOLD_BEAT_RATE_METER_ASSERT_SVH
`define THRESHOLD_BEAT_RATE_METER_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define TBRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define TBRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tbrm_pkg.sv
// Types and constants of the threshold beat rate meter.
`default_nettype none

package tbrm_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned BPM_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TUSER_W  = 3;
  localparam int unsigned STEP_W     = 4;

  localparam logic [SAMPLE_W-1:0]   THRESHOLD_RST = 10'd512;
  localparam logic [INTERVAL_W-1:0] MIN_INTV_RST  = 16'd300;
  localparam logic [INTERVAL_W-1:0] MAX_INTV_RST  = 16'd2000;
  localparam logic [BPM_W-1:0]      MINUTE_MS     = 16'd60000;
  localparam logic [STEP_W-1:0]     LAST_STEP     = 4'd15;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTV  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTV  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_WIN_LO,
    ST_WIN_HI,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: hdl/threshold_beat_rate_meter.sv
// Heart rate meter: threshold beat detection and an iterative rate divider.
//
// Samples enter on the s_ channel (sample and millisecond timestamp), one result
// leaves on the m_ channel for every sample: the current rate in tdata and the
// known, beat and updated flags in tuser. Thresholds are written through the cfg
// channel, which is ready outside reset and must only be used while the block is idle.
// Each item passes a small sequencer around one shared 33-bit subtractor: the
// interval, one or two window compares for a beat, and sixteen restoring
// division steps for 60000 / interval. A sample that is no beat and a beat
// outside the window skip the divider; only a beat inside the window runs it
// and updates the rate. The next item is taken once the sequencer is back in
// idle, after the result of the last one has been loaded into the output register.
// The result sits in an output register, so a new sample may be taken while
// the receiver stalls; a finished item waits in the sequencer until that
// register is free. Reset clears the registers to their defaults, the beat
// state, the last beat time and the rate, empties the output register and holds both inputs off.
`default_nettype none

module threshold_beat_rate_meter
  import tbrm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [S_TDATA_W-1:0]  s_tdata,   // sample [9:0], time_ms [41:10], zeros
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [BPM_W-1:0]           m_tdata,   // bpm [15:0]
  output logic [M_TUSER_W-1:0]       m_tuser,   // bpm_known [0], beat [1], bpm_updated [2]
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [SAMPLE_W-1:0]   threshold;
  logic [INTERVAL_W-1:0] min_interval_ms;
  logic [INTERVAL_W-1:0] max_interval_ms;

  logic                  above_flag;
  logic [TIME_W-1:0]     last_beat_time;
  logic [BPM_W-1:0]      rate_value;

  logic [SAMPLE_W-1:0]   sample_q;
  logic [TIME_W-1:0]     time_q;
  logic [TIME_W-1:0]     interval;
  logic [BPM_W:0]        rem;
  logic [BPM_W-1:0]      dvd;
  logic [STEP_W-1:0]     step;
  logic                  beat_q;
  logic                  updated_q;

  logic [TIME_W-1:0]     alu_a;
  logic [TIME_W-1:0]     alu_b;
  logic [TIME_W:0]       alu_res;
  logic                  alu_neg;
  logic [BPM_W:0]        rem_shift;
  logic                  beat_cond;
  logic                  in_accept;
  logic                  out_load;

  // The one shared subtractor; its borrow serves as the compare result.
  assign alu_res   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_neg   = alu_res[TIME_W];
  assign rem_shift = {rem[BPM_W-1:0], dvd[BPM_W-1]};
  assign beat_cond = (sample_q > threshold) && !above_flag;
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = !rst;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_DIFF;
      ST_DIFF:   state_next = beat_cond ? ST_WIN_LO : ST_DONE;
      ST_WIN_LO: state_next = alu_neg ? ST_WIN_HI : ST_DONE;
      ST_WIN_HI: state_next = alu_neg ? ST_DIV : ST_DONE;
      ST_DIV:    if (step == LAST_STEP) state_next = ST_DONE;
      ST_DONE:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    alu_a    = '0;
    alu_b    = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !rst;
      end
      ST_DIFF: begin
        alu_a = time_q;
        alu_b = last_beat_time;
      end
      ST_WIN_LO: begin
        // Borrow when min < interval.
        alu_a = {{(TIME_W-INTERVAL_W){1'b0}}, min_interval_ms};
        alu_b = interval;
      end
      ST_WIN_HI: begin
        // Borrow when interval < max.
        alu_a = interval;
        alu_b = {{(TIME_W-INTERVAL_W){1'b0}}, max_interval_ms};
      end
      ST_DIV: begin
        alu_a = {{(TIME_W-BPM_W-1){1'b0}}, rem_shift};
        alu_b = {{(TIME_W-INTERVAL_W){1'b0}}, interval[INTERVAL_W-1:0]};
      end
      ST_DONE: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= THRESHOLD_RST;
      min_interval_ms <= MIN_INTV_RST;
      max_interval_ms <= MAX_INTV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold       <= cfg_data[SAMPLE_W-1:0];
        REG_MIN_INTV:  min_interval_ms <= cfg_data;
        REG_MAX_INTV:  max_interval_ms <= cfg_data;
        default: begin
          threshold <= threshold;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      above_flag     <= 1'b0;
      last_beat_time <= '0;
      rate_value     <= '0;
    end else begin
      if (state == ST_DIFF) begin
        if (beat_cond) begin
          above_flag     <= 1'b1;
          last_beat_time <= time_q;
        end else if (sample_q < threshold) begin
          above_flag <= 1'b0;
        end
      end
      if (state == ST_DIV && step == LAST_STEP) begin
        rate_value <= {dvd[BPM_W-2:0], !alu_neg};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_q  <= s_tdata[SAMPLE_W-1:0];
      time_q    <= s_tdata[SAMPLE_W +: TIME_W];
      beat_q    <= 1'b0;
      updated_q <= 1'b0;
    end
    if (state == ST_DIFF) begin
      interval <= alu_res[TIME_W-1:0];
      beat_q   <= beat_cond;
    end
    if (state == ST_WIN_HI) begin
      rem  <= '0;
      dvd  <= MINUTE_MS;
      step <= '0;
    end
    if (state == ST_DIV) begin
      // Restoring division: keep the difference only when it did not borrow.
      rem  <= alu_neg ? rem_shift : alu_res[BPM_W:0];
      dvd  <= {dvd[BPM_W-2:0], !alu_neg};
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        updated_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= rate_value;
      m_tuser <= {updated_q, beat_q, (rate_value != '0)};
    end
  end

endmodule

`default_nettype wire

// File: hdl/tbrm_checker.sv
// Port-level assertions of the beat rate meter and their binding.
`default_nettype none

`include "threshold_beat_rate_meter_assert.svh"

module tbrm_checker
  import tbrm_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [S_TDATA_W-1:0] s_tdata,   // sample [9:0], time_ms [41:10], zeros
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [BPM_W-1:0]     m_tdata,   // bpm [15:0]
  input wire logic [M_TUSER_W-1:0] m_tuser    // bpm_known [0], beat [1], bpm_updated [2]
);

  logic                       out_stall;
  logic [BPM_W+M_TUSER_W-1:0] out_word;

  assign out_stall = m_tvalid && !m_tready;
  assign out_word  = {m_tdata, m_tuser};

  // A stalled item must hold its value until it is taken.
  `TBRM_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "result changed")

  // The known flag follows the rate itself.
  `TBRM_ASSERT_NOW(a_known_flag, m_tvalid, m_tuser[0] == (m_tdata != '0), "bpm_known wrong")

  // A new rate is only stored on a beat.
  `TBRM_ASSERT_NOW(a_update_beat, m_tvalid && m_tuser[2], m_tuser[1], "rate updated without a beat")

  // The sequencer is busy in the cycle after it takes a sample.
  `TBRM_ASSERT_NEXT(a_busy_after, s_tvalid && s_tready, !s_tready, "sample taken while busy")

endmodule

bind threshold_beat_rate_meter tbrm_checker u_tbrm_checker (.*);

`default_nettype wire
